[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each check is disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hdl/jcpe_pkg.sv]
package jcpe_pkg;

    localparam int PKT_LEN = 7;
    localparam int IDX_W = $clog2(PKT_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_LEN - 1);

    localparam int CMD_DEPTH = 2;
    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    localparam logic [7:0] BYTE_HEAD = 8'hFE;
    localparam logic [7:0] BYTE_MID = 8'h80;
    localparam logic [7:0] BYTE_TAIL = 8'hFF;
    localparam logic [7:0] BYTE_FILL_3 = 8'h01;
    localparam logic [7:0] BYTE_FILL_4 = 8'h02;
    localparam logic [7:0] BYTE_FILL_5 = 8'h03;

    localparam logic [7:0] CODE_DRIVE = 8'h00;
    localparam logic [7:0] CODE_STOP = 8'h30;
    localparam logic [7:0] CODE_RIGHT = 8'h33;
    localparam logic [7:0] CODE_LEFT = 8'h34;

    localparam logic [11:0] BTN_NONE = 12'h000;
    localparam logic [11:0] BTN_STOP = 12'h001;
    localparam logic [11:0] BTN_TOGGLE = 12'h002;
    localparam logic [11:0] BTN_LEFT = 12'h004;
    localparam logic [11:0] BTN_RIGHT = 12'h008;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEADZONE_PLANAR = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEADZONE_TWIST = 1'd1;
    localparam logic [8:0] DZ_PLANAR_RST = 9'd10;
    localparam logic [6:0] DZ_TWIST_RST = 7'd3;

    typedef struct packed {
        logic [9:0]  raw_x;
        logic [9:0]  raw_y;
        logic [7:0]  raw_z;
        logic [11:0] buttons;
    } t_in_word;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_out_word;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
    } t_cmd;

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] idx;
    } t_back_status;

    function automatic logic [7:0] pkt_byte(t_cmd c, logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = BYTE_HEAD;
            3'd1:    b = c.code;
            3'd2:    b = BYTE_MID;
            3'd3:    b = c.b3;
            3'd4:    b = c.b4;
            3'd5:    b = c.b5;
            default: b = BYTE_TAIL;
        endcase
        return b;
    endfunction

endpackage

[hdl/joystick_command_packet_encoder.sv]
// Joystick command packet encoder.
// Input side is a queue write port: a sample word (X, Y, twist, buttons) is taken
// at a clock edge where push is high and full is low. Every sample updates the
// stored button word and the drive-enable flag; it may also start one 7-byte packet.
// Output side is a queue read port: while empty is low the oldest packet byte is
// shown, and pop takes it. The last_byte bit marks the 0xFF trailer of each packet.
// Configuration writes set the two deadzones and are taken at once when enabled.
// The front end classifies and scales a sample in the cycle it is accepted and
// writes a command into a two-entry queue. The back end serializes one byte per
// cycle into an output register while the receiver is not stalling it. The first
// byte of a packet passes through the queue and the back end's command register
// before it reaches the output register. Samples are taken every cycle while the
// command queue has room; byte-by-byte draining bounds the sustained packet rate.
// When the receiver stalls, the shown byte holds, the back end stops, and the
// queue fills; full rises once two commands wait behind the one in progress.
// Synchronous reset empties everything, clears the flag and the stored buttons,
// and restores deadzones of 10 (planar) and 3 (twist).
`include "assert_macros.svh"

module joystick_command_packet_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [jcpe_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [jcpe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  jcpe_pkg::t_in_word               i_in_word,
    output logic                             empty,
    input  logic                             pop,
    output jcpe_pkg::t_out_word              o_out_word
);

    logic                   accept;
    logic                   cmd_wr_valid;
    jcpe_pkg::t_cmd         cmd_wr;
    logic                   cmd_rd_valid;
    jcpe_pkg::t_cmd         cmd_rd;
    logic                   cmd_pop;
    jcpe_pkg::t_back_status back_status;

    assign accept = push && !full;

    jcpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_word      (i_in_word),
        .o_cmd_valid (cmd_wr_valid),
        .o_cmd       (cmd_wr)
    );

    jcpe_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_wr_valid),
        .i_cmd   (cmd_wr),
        .i_pop   (cmd_pop),
        .o_full  (full),
        .o_valid (cmd_rd_valid),
        .o_cmd   (cmd_rd)
    );

    jcpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_rd_valid),
        .i_cmd       (cmd_rd),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_word      (o_out_word),
        .o_status    (back_status)
    );

    // A full queue only builds up behind a packet that is still being sent.
    `ASSERT_IMPLIES(a_full_means_busy, i_clk, i_rst_n, full, back_status.busy)
    // A shown byte that is not the trailer leaves more of its packet to send.
    `ASSERT_IMPLIES(a_mid_packet_busy, i_clk, i_rst_n, !empty && !o_out_word.last_byte,
        back_status.busy)
    // The byte index never runs past the trailer.
    `ASSERT_IMPLIES(a_idx_range, i_clk, i_rst_n, back_status.busy,
        back_status.idx <= jcpe_pkg::LAST_IDX)
    // Taking a trailer with no packet in progress leaves the output empty.
    `ASSERT_NEXT(a_trailer_drains, i_clk, i_rst_n,
        pop && !empty && o_out_word.last_byte && !back_status.busy, empty)

endmodule

[hdl/jcpe_front.sv]
module jcpe_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [jcpe_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [jcpe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_accept,
    input  jcpe_pkg::t_in_word               i_word,
    output logic                             o_cmd_valid,
    output jcpe_pkg::t_cmd                   o_cmd
);

    logic [8:0]  r_dz_planar;
    logic [6:0]  r_dz_twist;
    logic [11:0] r_prev;
    logic        r_drive;
    logic        n_drive;

    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic signed [8:0]  dz;
    logic [7:0]         sx_byte;
    logic [7:0]         sy_byte;
    logic [7:0]         sz_byte;
    logic               rel_stop;
    logic               rel_toggle;
    logic               rel_left;
    logic               rel_right;
    logic               emit;

    function automatic logic [7:0] scale_planar(logic signed [10:0] d, logic [8:0] zone);
        logic [10:0]        mag;
        logic signed [10:0] kept;
        logic signed [17:0] v;
        logic signed [17:0] q;
        mag = d[10] ? 11'(-d) : 11'(d);
        kept = (mag < {2'b00, zone}) ? 11'sd0 : d;
        v = 18'(kept) * 18'sd100 + 18'sd256;
        q = v[17] ? ((v + 18'sd511) >>> 9) : (v >>> 9);
        return 8'd128 + q[7:0];
    endfunction

    function automatic logic [7:0] scale_twist(logic signed [8:0] d, logic [6:0] zone);
        logic [8:0]         mag;
        logic signed [8:0]  kept;
        logic signed [15:0] v;
        logic signed [15:0] q;
        mag = d[8] ? 9'(-d) : 9'(d);
        kept = (mag < {2'b00, zone}) ? 9'sd0 : d;
        v = 16'(kept) * 16'sd100 + 16'sd64;
        q = v[15] ? ((v + 16'sd127) >>> 7) : (v >>> 7);
        return 8'd128 + q[7:0];
    endfunction

    always_comb begin
        dx = $signed({1'b0, i_word.raw_x}) - 11'sd512;
        dy = 11'sd512 - $signed({1'b0, i_word.raw_y});
        dz = $signed({1'b0, i_word.raw_z}) - 9'sd128;
        sx_byte = scale_planar(dx, r_dz_planar);
        sy_byte = scale_planar(dy, r_dz_planar);
        sz_byte = scale_twist(dz, r_dz_twist);
    end

    always_comb begin
        rel_stop = (r_prev == jcpe_pkg::BTN_STOP) && (i_word.buttons == jcpe_pkg::BTN_NONE);
        rel_toggle = (r_prev == jcpe_pkg::BTN_TOGGLE) && (i_word.buttons == jcpe_pkg::BTN_NONE);
        rel_left = (r_prev == jcpe_pkg::BTN_LEFT) && (i_word.buttons == jcpe_pkg::BTN_NONE);
        rel_right = (r_prev == jcpe_pkg::BTN_RIGHT) && (i_word.buttons == jcpe_pkg::BTN_NONE);
        n_drive = r_drive ^ rel_toggle;
        emit = 1'b1;
        o_cmd.code = jcpe_pkg::CODE_STOP;
        o_cmd.b3 = jcpe_pkg::BYTE_FILL_3;
        o_cmd.b4 = jcpe_pkg::BYTE_FILL_4;
        o_cmd.b5 = jcpe_pkg::BYTE_FILL_5;
        if (rel_stop) begin
            n_drive = 1'b0;
        end else if (n_drive) begin
            o_cmd.code = jcpe_pkg::CODE_DRIVE;
            o_cmd.b3 = sy_byte;
            o_cmd.b4 = sx_byte;
            o_cmd.b5 = sz_byte;
        end else if (rel_left) begin
            o_cmd.code = jcpe_pkg::CODE_LEFT;
        end else if (rel_right) begin
            o_cmd.code = jcpe_pkg::CODE_RIGHT;
        end else begin
            emit = 1'b0;
        end
        o_cmd_valid = i_accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz_planar <= jcpe_pkg::DZ_PLANAR_RST;
            r_dz_twist <= jcpe_pkg::DZ_TWIST_RST;
            r_prev <= jcpe_pkg::BTN_NONE;
            r_drive <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    jcpe_pkg::CFG_DEADZONE_PLANAR: r_dz_planar <= i_cfg_data;
                    jcpe_pkg::CFG_DEADZONE_TWIST:  r_dz_twist <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_prev <= i_word.buttons;
                r_drive <= n_drive;
            end
        end
    end

endmodule

[hdl/jcpe_cmd_fifo.sv]
module jcpe_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jcpe_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output jcpe_pkg::t_cmd o_cmd
);

    jcpe_pkg::t_cmd                r_mem [jcpe_pkg::CMD_DEPTH];
    logic [jcpe_pkg::PTR_W-1:0]    r_wr_ptr;
    logic [jcpe_pkg::PTR_W-1:0]    r_rd_ptr;
    logic [jcpe_pkg::CNT_W-1:0]    r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full = (r_count == jcpe_pkg::CNT_W'(jcpe_pkg::CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/jcpe_back.sv]
module jcpe_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  jcpe_pkg::t_cmd         i_cmd,
    output logic                   o_cmd_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output jcpe_pkg::t_out_word    o_word,
    output jcpe_pkg::t_back_status o_status
);

    jcpe_pkg::t_cmd                r_cmd;
    logic                          r_busy;
    logic [jcpe_pkg::IDX_W-1:0]    r_idx;
    logic                          r_out_valid;
    jcpe_pkg::t_out_word           r_out_word;
    logic                          out_ready;
    logic                          finishing;

    assign out_ready = !r_out_valid || i_pop;
    assign finishing = r_busy && out_ready && (r_idx == jcpe_pkg::LAST_IDX);
    assign o_cmd_pop = i_cmd_valid && (!r_busy || finishing);
    assign o_empty = !r_out_valid;
    assign o_word = r_out_word;
    assign o_status.busy = r_busy;
    assign o_status.idx = r_idx;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_busy && out_ready) begin
            r_out_word.tx_byte <= jcpe_pkg::pkt_byte(r_cmd, r_idx);
            r_out_word.last_byte <= (r_idx == jcpe_pkg::LAST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_busy && out_ready) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (o_cmd_pop) begin
                r_busy <= 1'b1;
                r_idx <= '0;
            end else begin
                if (finishing) begin
                    r_busy <= 1'b0;
                end
                if (r_busy && out_ready) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

endmodule

[tb/tb_joystick_command_packet_encoder.sv]
module tb_joystick_command_packet_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    class packet_scoreboard;
        int unsigned         zone_planar;
        int unsigned         zone_twist;
        logic [11:0]         last_buttons;
        bit                  drive_on;
        jcpe_pkg::t_out_word expected_bytes[$];
        int                  mismatches;

        function new();
            zone_planar = jcpe_pkg::DZ_PLANAR_RST;
            zone_twist = jcpe_pkg::DZ_TWIST_RST;
            last_buttons = jcpe_pkg::BTN_NONE;
            drive_on = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [jcpe_pkg::CFG_ADDR_W-1:0] addr,
                              logic [jcpe_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                jcpe_pkg::CFG_DEADZONE_PLANAR: zone_planar = data;
                jcpe_pkg::CFG_DEADZONE_TWIST: zone_twist = data[6:0];
                default: ;
            endcase
        endfunction

        // Zero the offset inside the deadzone, then scale to a rounded percentage.
        function int percent(int d, int unsigned zone, int span);
            int mag;
            mag = (d < 0) ? -d : d;
            if (mag < zone)
                d = 0;
            return (100 * d + span / 2) / span;
        endfunction

        function bit released(logic [11:0] prev, logic [11:0] cur, logic [11:0] btn);
            return (prev == btn) && (cur == jcpe_pkg::BTN_NONE);
        endfunction

        function void note_sample(jcpe_pkg::t_in_word w);
            int                  sx;
            int                  sy;
            int                  sz;
            logic [11:0]         prev;
            logic [7:0]          pkt [0:6];
            bit                  send_pkt;
            jcpe_pkg::t_out_word ob;

            sx = percent(int'(w.raw_x) - 512, zone_planar, 512);
            sy = percent(512 - int'(w.raw_y), zone_planar, 512);
            sz = percent(int'(w.raw_z) - 128, zone_twist, 128);
            prev = last_buttons;
            last_buttons = w.buttons;
            if (released(prev, w.buttons, jcpe_pkg::BTN_TOGGLE))
                drive_on = !drive_on;

            pkt[0] = jcpe_pkg::BYTE_HEAD;
            pkt[2] = jcpe_pkg::BYTE_MID;
            pkt[3] = jcpe_pkg::BYTE_FILL_3;
            pkt[4] = jcpe_pkg::BYTE_FILL_4;
            pkt[5] = jcpe_pkg::BYTE_FILL_5;
            pkt[6] = jcpe_pkg::BYTE_TAIL;
            send_pkt = 1'b1;
            if (released(prev, w.buttons, jcpe_pkg::BTN_STOP)) begin
                drive_on = 1'b0;
                pkt[1] = jcpe_pkg::CODE_STOP;
            end else if (drive_on) begin
                pkt[1] = jcpe_pkg::CODE_DRIVE;
                pkt[3] = 8'(128 + sy);
                pkt[4] = 8'(128 + sx);
                pkt[5] = 8'(128 + sz);
            end else if (released(prev, w.buttons, jcpe_pkg::BTN_LEFT)) begin
                pkt[1] = jcpe_pkg::CODE_LEFT;
            end else if (released(prev, w.buttons, jcpe_pkg::BTN_RIGHT)) begin
                pkt[1] = jcpe_pkg::CODE_RIGHT;
            end else begin
                send_pkt = 1'b0;
            end

            if (send_pkt) begin
                for (int i = 0; i < jcpe_pkg::PKT_LEN; i++) begin
                    ob.tx_byte = pkt[i];
                    ob.last_byte = (i == jcpe_pkg::PKT_LEN - 1);
                    expected_bytes.push_back(ob);
                end
            end
        endfunction

        function void check_byte(jcpe_pkg::t_out_word got);
            jcpe_pkg::t_out_word exp_word;
            if (expected_bytes.size() == 0) begin
                $error("unexpected word: tx_byte %02h, last_byte %0b",
                       got.tx_byte, got.last_byte);
                mismatches++;
                return;
            end
            exp_word = expected_bytes.pop_front();
            if (got.tx_byte !== exp_word.tx_byte) begin
                $error("tx_byte: expected %02h, actual %02h", exp_word.tx_byte, got.tx_byte);
                mismatches++;
            end
            if (got.last_byte !== exp_word.last_byte) begin
                $error("last_byte: expected %0b, actual %0b",
                       exp_word.last_byte, got.last_byte);
                mismatches++;
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [jcpe_pkg::CFG_ADDR_W-1:0] i_cfg_addr = jcpe_pkg::CFG_DEADZONE_PLANAR;
    logic [jcpe_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            push = 1'b0;
    logic                            full;
    jcpe_pkg::t_in_word              i_in_word = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    jcpe_pkg::t_out_word             o_out_word;

    packet_scoreboard sb = new();
    int burst_left = 0;
    int rx_cycle = 0;

    joystick_command_packet_encoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle / 150) % 3)
                0: pop <= 1'b1;
                1: pop <= ($urandom % 3) != 0;
                default: pop <= (rx_cycle % 7) < 4;
            endcase
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_byte(o_out_word);
    end

    function automatic jcpe_pkg::t_in_word sample_of(int x, int y, int z, logic [11:0] btn);
        jcpe_pkg::t_in_word w;
        w.raw_x = 10'(x);
        w.raw_y = 10'(y);
        w.raw_z = 8'(z);
        w.buttons = btn;
        return w;
    endfunction

    function automatic int axis_pos(int unsigned zone, int centre, int top);
        int v;
        int off;
        case ($urandom_range(0, 3))
            0: begin
                off = int'(zone) - 1 + int'($urandom_range(0, 2));
                v = $urandom_range(0, 1) ? centre + off : centre - off;
            end
            1: v = $urandom_range(0, 1) ? top : 0;
            default: v = $urandom_range(0, top);
        endcase
        if (v < 0)
            v = 0;
        if (v > top)
            v = top;
        return v;
    endfunction

    function automatic jcpe_pkg::t_in_word rand_sample(logic [11:0] btn);
        return sample_of(axis_pos(sb.zone_planar, 512, 1023), axis_pos(sb.zone_planar, 512, 1023),
                         axis_pos(sb.zone_twist, 128, 255), btn);
    endfunction

    function automatic logic [11:0] one_button();
        case ($urandom_range(0, 3))
            0: return jcpe_pkg::BTN_STOP;
            1: return jcpe_pkg::BTN_TOGGLE;
            2: return jcpe_pkg::BTN_LEFT;
            default: return jcpe_pkg::BTN_RIGHT;
        endcase
    endfunction

    task automatic send(jcpe_pkg::t_in_word w);
        bit took;
        push <= 1'b1;
        i_in_word <= w;
        do begin
            @(negedge i_clk);
            took = !full;
            @(posedge i_clk);
        end while (!took);
        sb.note_sample(w);
    endtask

    task automatic hold(int n);
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_paced(jcpe_pkg::t_in_word w);
        send(w);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            hold($urandom_range(1, 12));
            burst_left = $urandom_range(0, 10);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        while (sb.expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_deadzones(logic [jcpe_pkg::CFG_DATA_W-1:0] planar,
                                   logic [jcpe_pkg::CFG_DATA_W-1:0] twist);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= jcpe_pkg::CFG_DEADZONE_PLANAR;
        i_cfg_data <= planar;
        @(posedge i_clk);
        sb.set_reg(jcpe_pkg::CFG_DEADZONE_PLANAR, planar);
        i_cfg_addr <= jcpe_pkg::CFG_DEADZONE_TWIST;
        i_cfg_data <= twist;
        @(posedge i_clk);
        sb.set_reg(jcpe_pkg::CFG_DEADZONE_TWIST, twist);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int          done;
        logic [11:0] b;
        done = 0;
        while (done < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    send_paced(rand_sample(one_button()));
                    send_paced(rand_sample(jcpe_pkg::BTN_NONE));
                    done += 2;
                end
                4, 5, 6: begin
                    send_paced(rand_sample(jcpe_pkg::BTN_NONE));
                    done += 1;
                end
                7: begin
                    send_paced(rand_sample(12'($urandom)));
                    done += 1;
                end
                8: begin
                    send_paced(rand_sample(one_button()));
                    send_paced(rand_sample(12'($urandom_range(1, 4095))));
                    done += 2;
                end
                default: begin
                    b = 12'($urandom);
                    b[$urandom_range(0, 3)] = 1'b1;
                    b[$urandom_range(4, 11)] = 1'b1;
                    send_paced(rand_sample(b));
                    send_paced(rand_sample(jcpe_pkg::BTN_NONE));
                    done += 2;
                end
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A press and release of the toggle button arms drive packets.
        send_paced(sample_of(512, 512, 128, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(0, 1023, 0, 12'hFFF));
        send_paced(sample_of(1023, 0, 255, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(512, 512, 128, jcpe_pkg::BTN_TOGGLE));
        send_paced(sample_of(1023, 0, 255, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(0, 1023, 0, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(521, 502, 130, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(503, 522, 125, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(511, 513, 127, jcpe_pkg::BTN_LEFT));
        send_paced(sample_of(700, 300, 200, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(512, 512, 128, jcpe_pkg::BTN_STOP));
        send_paced(sample_of(100, 900, 40, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(512, 512, 128, jcpe_pkg::BTN_LEFT));
        send_paced(sample_of(512, 512, 128, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(512, 512, 128, jcpe_pkg::BTN_RIGHT));
        send_paced(sample_of(512, 512, 128, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(512, 512, 128, 12'h00C));
        send_paced(sample_of(512, 512, 128, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(300, 800, 60, jcpe_pkg::BTN_TOGGLE));
        send_paced(sample_of(300, 800, 60, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(300, 800, 60, jcpe_pkg::BTN_TOGGLE));
        send_paced(sample_of(300, 800, 60, jcpe_pkg::BTN_NONE));
        send_paced(sample_of(512, 512, 128, jcpe_pkg::BTN_STOP));
        send_paced(sample_of(512, 512, 128, jcpe_pkg::BTN_NONE));
        drain();

        random_phase(20);
        drain();
        random_phase(15);
        drain();

        write_deadzones(9'd0, 9'd0);
        random_phase(30);
        drain();

        write_deadzones(9'd511, 9'h1FF);
        random_phase(20);
        drain();

        write_deadzones(9'($urandom_range(0, 511)), 9'($urandom));
        random_phase(15);
        drain();

        write_deadzones(jcpe_pkg::DZ_PLANAR_RST, 9'(jcpe_pkg::DZ_TWIST_RST));
        random_phase(10);

        push <= 1'b0;
        while (sb.expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/jcpe_pkg.sv
hdl/jcpe_front.sv
hdl/jcpe_cmd_fifo.sv
hdl/jcpe_back.sv
hdl/joystick_command_packet_encoder.sv
tb/tb_joystick_command_packet_encoder.sv
